// ===== rtl/irbft_pkg.sv =====
// Shared types, constants and the frame builder for the infrared biphase frame transmitter.
`default_nettype none
package irbft_pkg;

  localparam int TICK_COUNT_BITS = 8;
  localparam int FRAME_SLOTS     = 40;
  localparam int SLOT_IDX_W      = 6;
  localparam int HALF_SLOT_W     = 8;
  localparam int CFG_INDEX_W     = 8;
  localparam int CFG_DATA_W      = 8;
  localparam logic START_MARK    = 1'b1;
  localparam logic [HALF_SLOT_W-1:0] HALF_SLOT_RESET = 8'd20;
  localparam logic CARRIER_RESET = 1'b1;

  typedef logic [FRAME_SLOTS-1:0] frame_t;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_SEND = 1'b1
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_HALF_SLOT_TICKS = 8'd0,
    CFG_CARRIER_TOGGLE  = 8'd1
  } cfg_index_t;

  typedef struct packed {
    logic rejected;
    logic frame_done;
    logic busy_res;
    logic pin_level;
  } irbft_res_t;

  // Pre-pulse, start bit, then command and address bytes with the least significant bit first.
  function automatic frame_t build_frame(input logic [7:0] c, input logic [7:0] a);
    frame_t p;
    p = '0;
    p[0] = START_MARK;
    p[6] = START_MARK;
    for (int i = 0; i < 8; i++) begin
      p[8 + 2*i]  = c[i];
      p[9 + 2*i]  = ~c[i];
      p[24 + 2*i] = a[i];
      p[25 + 2*i] = ~a[i];
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/irbft_core.sv =====
// Frame state and per-transaction pin sequencing of the infrared biphase frame transmitter.
`default_nettype none
module irbft_core
  import irbft_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   accept,
  input  wire logic                   cmd,
  input  wire logic [7:0]             command_byte,
  input  wire logic [7:0]             address_byte,
  input  wire logic [HALF_SLOT_W-1:0] half_slot_ticks,
  input  wire logic                   carrier_toggle,
  output irbft_res_t                  res
);

  localparam int CMP_W = (TICK_COUNT_BITS + 1 > HALF_SLOT_W + 1) ?
                         TICK_COUNT_BITS + 1 : HALF_SLOT_W + 1;
  localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'((2 ** TICK_COUNT_BITS) - 1);

  frame_t                      slot_pattern, slot_pattern_next;
  logic [SLOT_IDX_W-1:0]       slot_index, slot_index_next;
  logic [TICK_COUNT_BITS-1:0]  tick_count, tick_count_next;
  logic                        pin_state, pin_state_next;
  logic                        active, active_next;

  frame_t                      pat_shift;
  logic                        slot_on;
  logic [HALF_SLOT_W-1:0]      limit;
  logic [CMP_W-1:0]            cnt_inc;
  logic [SLOT_IDX_W-1:0]       slot_inc;
  logic                        pin_now;

  always_comb begin
    slot_pattern_next = slot_pattern;
    slot_index_next   = slot_index;
    tick_count_next   = tick_count;
    pin_state_next    = pin_state;
    active_next       = active;
    pin_now           = pin_state;
    res               = '0;

    pat_shift = slot_pattern >> slot_index;
    slot_on   = (slot_index < SLOT_IDX_W'(FRAME_SLOTS)) && pat_shift[0];
    limit     = (half_slot_ticks == '0) ? HALF_SLOT_W'(1) : half_slot_ticks;
    cnt_inc   = CMP_W'(tick_count) + CMP_W'(1);
    slot_inc  = slot_index + SLOT_IDX_W'(1);

    if (cmd == CMD_SEND) begin
      if (active) begin
        res.rejected = 1'b1;
      end else begin
        slot_pattern_next = build_frame(command_byte, address_byte);
        slot_index_next   = '0;
        tick_count_next   = '0;
        active_next       = 1'b1;
      end
    end else if (!active) begin
      pin_now = 1'b0;
    end else begin
      if (slot_on) begin
        pin_now = carrier_toggle ? ~pin_state : 1'b1;
      end else begin
        pin_now = 1'b0;
      end
      if (cnt_inc >= CMP_W'(limit) || cnt_inc > CNT_MAX) begin
        tick_count_next = '0;
        if (slot_inc >= SLOT_IDX_W'(FRAME_SLOTS)) begin
          res.frame_done  = 1'b1;
          active_next     = 1'b0;
          slot_index_next = '0;
        end else begin
          slot_index_next = slot_inc;
        end
      end else begin
        tick_count_next = cnt_inc[TICK_COUNT_BITS-1:0];
      end
    end

    res.pin_level  = pin_now;
    res.busy_res   = active_next;
    pin_state_next = res.frame_done ? 1'b0 : pin_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_pattern <= '0;
      slot_index   <= '0;
      tick_count   <= '0;
      pin_state    <= 1'b0;
      active       <= 1'b0;
    end else if (accept) begin
      slot_pattern <= slot_pattern_next;
      slot_index   <= slot_index_next;
      tick_count   <= tick_count_next;
      pin_state    <= pin_state_next;
      active       <= active_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ir_biphase_frame_transmitter_top.sv =====
// Top level of the infrared biphase frame transmitter: stream ports, registers and result stage.
//
// Each input transaction is either a tick (s_tuser low) or a send request (s_tuser high)
// carrying the command byte in s_tdata[7:0] and the address byte in s_tdata[15:8].
// A send while idle loads a 40 half-slot frame; a send while busy is flagged as rejected.
// Every input transaction produces exactly one output transaction holding the pin level,
// the busy flag and the rejected flag; m_tlast marks the tick that ends the frame.
// The result appears on the master side in the cycle after the input is accepted; while
// the receiver keeps up, one item can be accepted in every cycle, so throughput is one item per clock.
// The output register is the only buffer: s_tready is high whenever it is empty or is
// being emptied in the same cycle, so a stalled receiver stalls the input side.
// Configuration writes are always taken (cfg_ready is tied high): index 0 sets the ticks
// per half slot, index 1 selects carrier toggling; other indexes are ignored.
// Reset idles the block, drives the pin low, empties the output register and restores
// 20 ticks per half slot with carrier toggling enabled.
`default_nettype none
module ir_biphase_frame_transmitter_top
  import irbft_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [15:0]            s_tdata,   // command_byte, address_byte
  input  wire logic                   s_tuser,   // cmd
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [7:0]                  m_tdata,   // pin_level, busy_res, rejected, zero pad
  output logic                        m_tlast,   // frame_done
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [HALF_SLOT_W-1:0] half_slot_ticks;
  logic                   carrier_toggle;
  logic                   accept;
  irbft_res_t             core_res;
  irbft_res_t             out_res;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_slot_ticks <= HALF_SLOT_RESET;
      carrier_toggle  <= CARRIER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HALF_SLOT_TICKS: half_slot_ticks <= cfg_data[HALF_SLOT_W-1:0];
        CFG_CARRIER_TOGGLE:  carrier_toggle  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  irbft_core u_core (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .cmd             (s_tuser),
    .command_byte    (s_tdata[7:0]),
    .address_byte    (s_tdata[15:8]),
    .half_slot_ticks (half_slot_ticks),
    .carrier_toggle  (carrier_toggle),
    .res             (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res <= core_res;
    end
  end

  assign m_tdata = {5'b0, out_res.rejected, out_res.busy_res, out_res.pin_level};
  assign m_tlast = out_res.frame_done;

  // A finished frame is never reported as still busy.
  assert property (@(posedge clk) disable iff (rst) m_tvalid && m_tlast |-> !m_tdata[1])
    else $error("frame end reported while busy");

  // A rejected send can only happen while a frame is in flight.
  assert property (@(posedge clk) disable iff (rst) m_tvalid && m_tdata[2] |-> m_tdata[1])
    else $error("rejection reported while idle");

  // A send and a frame end cannot share one transaction.
  assert property (@(posedge clk) disable iff (rst) m_tvalid && m_tlast |-> !m_tdata[2])
    else $error("frame end and rejection in one transaction");

  // Every accepted item yields a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst) accept |=> m_tvalid)
    else $error("accepted item produced no result");

  // The input side is open whenever the output register is empty.
  assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

endmodule
`default_nettype wire
